// ===== rtl/toy_cpu_execute_unit_assert.svh =====
// Assertion macros shared by the execute unit
`ifndef TOY_CPU_EXECUTE_UNIT_ASSERT_SVH
`define TOY_CPU_EXECUTE_UNIT_ASSERT_SVH

// Same-cycle implication
`define TCEU_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication
`define TCEU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/tceu_pkg.sv =====
package tceu_pkg;

   localparam logic [3:0] OP_MOV  = 4'd0;
   localparam logic [3:0] OP_ADD  = 4'd1;
   localparam logic [3:0] OP_MUL  = 4'd2;
   localparam logic [3:0] OP_SUB  = 4'd3;
   localparam logic [3:0] OP_DIV  = 4'd4;
   localparam logic [3:0] OP_AND  = 4'd5;
   localparam logic [3:0] OP_OR   = 4'd6;
   localparam logic [3:0] OP_NOT  = 4'd7;
   localparam logic [3:0] OP_BZ   = 4'd8;
   localparam logic [3:0] OP_BNZ  = 4'd9;
   localparam logic [3:0] OP_BNEG = 4'd10;
   localparam logic [3:0] OP_BPOS = 4'd11;

   localparam logic [1:0] MODE_IMM = 2'd0;
   localparam logic [1:0] MODE_REG = 2'd1;
   localparam logic [1:0] MODE_DIR = 2'd2;
   localparam logic [1:0] MODE_IND = 2'd3;

   localparam int DIV_STEPS = 16;

   typedef struct packed {
      logic [3:0]  action;
      logic [1:0]  dest_mode;
      logic [15:0] dest_operand;
      logic [1:0]  src_mode;
      logic [15:0] src_operand;
      logic [7:0]  jump_target;
   } req_type;

   typedef struct packed {
      logic signed [15:0] result_value;
      logic signed [15:0] reg_ax;
      logic signed [15:0] reg_bx;
      logic signed [15:0] reg_cx;
      logic signed [15:0] reg_dx;
      logic               flag_zero;
      logic               flag_negative;
      logic               flag_overflow;
      logic               branch_taken;
      logic [7:0]         branch_target;
      logic               fault;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DECODE,
      ST_D_START,
      ST_D_PTR,
      ST_D_DATA,
      ST_S_START,
      ST_S_PTR,
      ST_S_DATA,
      ST_EXEC,
      ST_DIV,
      ST_WRITE,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic cap_req;
      logic clear_step;
      logic decode;
      logic op_start;
      logic op_ptr;
      logic op_data;
      logic sel_src;
      logic exec;
      logic div_load;
      logic write_back;
   } cmd_type;

   typedef struct packed {
      logic       is_alu;
      logic [1:0] mode;
      logic       addr_bad;
      logic       ptr_bad;
      logic       div_nz;
      logic       div_done;
      logic       clear_done;
   } status_type;

endpackage

// ===== rtl/toy_cpu_execute_unit.sv =====
// Channel | Ports                          | Carries
// req     | req_valid req_ready req_data   | one decoded instruction item
// rsp     | rsp_valid rsp_ready rsp_data   | one result item per instruction
//
// One item at a time: a branch or an undefined opcode goes from decode
// straight to the result; the other operations fetch the destination and
// then the source operand (one RAM access direct, two for indirect), execute,
// run the divider for a divide by a nonzero value, and write back. A RAM
// fault ends the item early. After reset a clearing pass zeroes the data RAM
// before the first item is taken.
// A stalled result holds in its registers until rsp_ready.
`include "toy_cpu_execute_unit_assert.svh"

module toy_cpu_execute_unit #(
   parameter int RAM_WORDS     = 2048,
   parameter int PROGRAM_WORDS = 256
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  tceu_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output tceu_pkg::rsp_type rsp_data
);
   import tceu_pkg::*;

   cmd_type    cmd;
   status_type status;

   // sequencer: walks decode, operand fetch, execute, write back
   tceu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // registers, flags, data RAM, ALU and divider
   tceu_dpath #(
      .RAM_WORDS     (RAM_WORDS),
      .PROGRAM_WORDS (PROGRAM_WORDS)
   ) u_dpath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .status   (status),
      .rsp_data (rsp_data)
   );

   // a faulted item reports no result and no branch
   `TCEU_ASSERT_NOW(a_fault_quiet, clock, reset, rsp_valid && rsp_data.fault, rsp_data.result_value == 16'sd0 && !rsp_data.branch_taken, "fault item reports a result")
   // untaken branch reports a zero target
   `TCEU_ASSERT_NOW(a_target_zero, clock, reset, rsp_valid && !rsp_data.branch_taken, rsp_data.branch_target == 8'd0, "target set without branch")
   // never take an item while a result waits
   `TCEU_ASSERT_NOW(a_one_item, clock, reset, req_ready, !rsp_valid, "input taken while result pending")
   // delivering a result returns to accepting items
   `TCEU_ASSERT_NEXT(a_back_idle, clock, reset, rsp_valid && rsp_ready, req_ready && !rsp_valid, "no return to idle")

endmodule

// ===== rtl/tceu_div.sv =====
module tceu_div (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [15:0] dividend,
   input  logic signed [15:0] divisor,
   output logic               done,
   output logic [15:0]        quotient
);
   import tceu_pkg::*;

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic [16:0] rem_ff, rem_in;
   logic [15:0] quo_ff, quo_in;
   logic [15:0] den_ff, den_in;
   logic        neg_ff, neg_in;
   logic [16:0] shifted;
   logic [16:0] diff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      shifted = {rem_ff[15:0], quo_ff[15]};
      diff    = shifted - {1'b0, den_ff};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend[15] ? 16'(-dividend) : dividend;
         den_in  = divisor[15] ? 16'(-divisor) : divisor;
         neg_in  = dividend[15] ^ divisor[15];
      end else if (busy_ff) begin
         // restoring step: one quotient bit
         if (!diff[16]) begin
            rem_in = diff;
            quo_in = {quo_ff[14:0], 1'b1};
         end else begin
            rem_in = shifted;
            quo_in = {quo_ff[14:0], 1'b0};
         end
         cnt_in = cnt_ff + 4'd1;
         if (cnt_ff == 4'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? 16'(-quo_ff) : quo_ff;

endmodule

// ===== rtl/tceu_dpath.sv =====
module tceu_dpath #(
   parameter int RAM_WORDS     = 2048,
   parameter int PROGRAM_WORDS = 256
) (
   input  logic                 clock,
   input  logic                 reset,
   input  tceu_pkg::req_type    req_data,
   input  tceu_pkg::cmd_type    cmd,
   output tceu_pkg::status_type status,
   output tceu_pkg::rsp_type    rsp_data
);
   import tceu_pkg::*;

   localparam int AW = (RAM_WORDS > 1) ? $clog2(RAM_WORDS) : 1;
   localparam int RECIP = (65536 + PROGRAM_WORDS - 1) / PROGRAM_WORDS;

   req_type     req_ff;
   logic [15:0] d_val_ff, s_val_ff;
   logic [AW-1:0] d_idx_ff;
   logic [15:0] r_ff;
   logic        fault_ff, taken_ff;
   logic [7:0]  target_ff;
   logic [15:0] regs_ff [4];
   logic        zf_ff, nf_ff, of_ff;
   logic [AW-1:0] clr_cnt_ff;
   logic [15:0] mem [RAM_WORDS];
   logic [15:0] rd_data_ff;

   logic [1:0]  cur_mode;
   logic [15:0] cur_opnd;
   logic        addr_bad, ptr_bad;
   logic        rd_en;
   logic [AW-1:0] rd_addr;
   logic        wr_en;
   logic [AW-1:0] wr_addr;
   logic [15:0] wr_data;
   logic signed [15:0] a_val, b_val;
   logic signed [16:0] sum;
   logic signed [31:0] prod;
   logic [15:0] alu_r;
   logic        alu_ov;
   logic        taken;
   logic [24:0] quot_prod;
   logic [7:0]  tgt_q;
   logic [24:0] tgt_rem;
   logic        div_done;
   logic [15:0] div_quot;

   assign cur_mode = cmd.sel_src ? req_ff.src_mode : req_ff.dest_mode;
   assign cur_opnd = cmd.sel_src ? req_ff.src_operand : req_ff.dest_operand;
   assign addr_bad = {1'b0, cur_opnd} >= 17'(RAM_WORDS);
   assign ptr_bad  = rd_data_ff[15] || ({1'b0, rd_data_ff} >= 17'(RAM_WORDS));

   assign a_val = d_val_ff;
   assign b_val = s_val_ff;
   assign sum   = {a_val[15], a_val} + {b_val[15], b_val};
   assign prod  = a_val * b_val;

   // ALU for everything but the divide quotient
   always_comb begin
      alu_ov = 1'b0;
      case (req_ff.action)
         OP_MOV: alu_r = s_val_ff;
         OP_ADD: begin
            alu_ov = sum > 17'sd255;
            alu_r  = alu_ov ? {8'h00, sum[7:0]} : sum[15:0];
         end
         OP_MUL: begin
            alu_ov = prod > 32'sd255;
            alu_r  = alu_ov ? {8'h00, prod[7:0]} : prod[15:0];
         end
         OP_SUB: alu_r = d_val_ff - s_val_ff;
         OP_AND: alu_r = {8'h00, d_val_ff[7:0] & s_val_ff[7:0]};
         OP_OR:  alu_r = {8'h00, d_val_ff[7:0] | s_val_ff[7:0]};
         OP_NOT: alu_r = 16'd255 - d_val_ff;
         default: alu_r = d_val_ff;
      endcase
   end

   always_comb begin
      case (req_ff.action)
         OP_BZ:   taken = zf_ff;
         OP_BNZ:  taken = !zf_ff;
         OP_BNEG: taken = nf_ff;
         OP_BPOS: taken = !nf_ff;
         default: taken = 1'b0;
      endcase
   end

   // jump target modulo program size by reciprocal multiply
   assign quot_prod = 25'(req_ff.jump_target) * 25'(RECIP);
   assign tgt_q     = quot_prod[23:16];
   assign tgt_rem   = 25'(req_ff.jump_target) - 25'(tgt_q) * 25'(PROGRAM_WORDS);

   tceu_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.exec && status.div_nz),
      .dividend (a_val),
      .divisor  (b_val),
      .done     (div_done),
      .quotient (div_quot)
   );

   always_comb begin
      rd_en   = 1'b0;
      rd_addr = cur_opnd[AW-1:0];
      if (cmd.op_start && cur_mode[1] && !addr_bad) begin
         rd_en = 1'b1;
      end else if (cmd.op_ptr && !ptr_bad) begin
         rd_en   = 1'b1;
         rd_addr = rd_data_ff[AW-1:0];
      end
   end

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = d_idx_ff;
      wr_data = r_ff;
      if (cmd.clear_step) begin
         wr_en   = 1'b1;
         wr_addr = clr_cnt_ff;
         wr_data = '0;
      end else if (cmd.write_back && req_ff.dest_mode[1]) begin
         wr_en = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
         zf_ff      <= 1'b0;
         nf_ff      <= 1'b0;
         of_ff      <= 1'b0;
         for (int i = 0; i < 4; i++) begin
            regs_ff[i] <= '0;
         end
      end else begin
         if (cmd.clear_step) begin
            clr_cnt_ff <= clr_cnt_ff + AW'(1);
         end
         if (cmd.exec) begin
            of_ff <= of_ff | alu_ov;
         end
         if (cmd.write_back) begin
            if (r_ff == 16'd0) begin
               zf_ff <= 1'b1;
            end else begin
               zf_ff <= 1'b0;
               nf_ff <= r_ff[15];
            end
            if (req_ff.dest_mode == MODE_REG) begin
               regs_ff[req_ff.dest_operand[1:0]] <= r_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.cap_req) begin
         req_ff    <= req_data;
         r_ff      <= '0;
         fault_ff  <= 1'b0;
         taken_ff  <= 1'b0;
         target_ff <= '0;
      end
      if (cmd.decode) begin
         taken_ff  <= taken;
         target_ff <= taken ? tgt_rem[7:0] : 8'd0;
      end
      if (cmd.op_start) begin
         if (cur_mode[1] && addr_bad) begin
            fault_ff <= 1'b1;
         end
         if (!cmd.sel_src) begin
            d_idx_ff <= cur_opnd[AW-1:0];
         end
         if (cur_mode == MODE_IMM || cur_mode == MODE_REG) begin
            if (cmd.sel_src) begin
               s_val_ff <= cur_mode[0] ? regs_ff[cur_opnd[1:0]] : cur_opnd;
            end else begin
               d_val_ff <= cur_mode[0] ? regs_ff[cur_opnd[1:0]] : cur_opnd;
            end
         end
      end
      if (cmd.op_ptr) begin
         if (ptr_bad) begin
            fault_ff <= 1'b1;
         end
         if (!cmd.sel_src) begin
            d_idx_ff <= rd_data_ff[AW-1:0];
         end
      end
      if (cmd.op_data) begin
         if (cmd.sel_src) begin
            s_val_ff <= rd_data_ff;
         end else begin
            d_val_ff <= rd_data_ff;
         end
      end
      if (cmd.exec) begin
         r_ff <= alu_r;
      end
      if (cmd.div_load) begin
         r_ff <= div_quot;
      end
   end

   always_comb begin
      status.is_alu     = !req_ff.action[3];
      status.mode       = cur_mode;
      status.addr_bad   = addr_bad;
      status.ptr_bad    = ptr_bad;
      status.div_nz     = (req_ff.action == OP_DIV) && (s_val_ff != 16'd0);
      status.div_done   = div_done;
      status.clear_done = clr_cnt_ff == AW'(RAM_WORDS - 1);
   end

   always_comb begin
      rsp_data.result_value  = r_ff;
      rsp_data.reg_ax        = regs_ff[0];
      rsp_data.reg_bx        = regs_ff[1];
      rsp_data.reg_cx        = regs_ff[2];
      rsp_data.reg_dx        = regs_ff[3];
      rsp_data.flag_zero     = zf_ff;
      rsp_data.flag_negative = nf_ff;
      rsp_data.flag_overflow = of_ff;
      rsp_data.branch_taken  = taken_ff;
      rsp_data.branch_target = target_ff;
      rsp_data.fault         = fault_ff;
   end

endmodule

// ===== rtl/tceu_ctrl.sv =====
module tceu_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  tceu_pkg::status_type status,
   output tceu_pkg::cmd_type    cmd
);
   import tceu_pkg::*;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR:  if (status.clear_done) state_in = ST_IDLE;
         ST_IDLE:   if (req_valid) state_in = ST_DECODE;
         ST_DECODE: state_in = status.is_alu ? ST_D_START : ST_RESP;
         ST_D_START, ST_S_START: begin
            case (status.mode)
               MODE_DIR: state_in = status.addr_bad ? ST_RESP :
                                    (state_ff == ST_D_START ? ST_D_DATA : ST_S_DATA);
               MODE_IND: state_in = status.addr_bad ? ST_RESP :
                                    (state_ff == ST_D_START ? ST_D_PTR : ST_S_PTR);
               default:  state_in = (state_ff == ST_D_START) ? ST_S_START : ST_EXEC;
            endcase
         end
         ST_D_PTR:  state_in = status.ptr_bad ? ST_RESP : ST_D_DATA;
         ST_S_PTR:  state_in = status.ptr_bad ? ST_RESP : ST_S_DATA;
         ST_D_DATA: state_in = ST_S_START;
         ST_S_DATA: state_in = ST_EXEC;
         ST_EXEC:   state_in = status.div_nz ? ST_DIV : ST_WRITE;
         ST_DIV:    if (status.div_done) state_in = ST_WRITE;
         ST_WRITE:  state_in = ST_RESP;
         ST_RESP:   if (rsp_ready) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd            = '0;
      req_ready      = 1'b0;
      rsp_valid      = 1'b0;
      case (state_ff)
         ST_CLEAR:   cmd.clear_step = 1'b1;
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.cap_req = req_valid;
         end
         ST_DECODE:  cmd.decode = 1'b1;
         ST_D_START: cmd.op_start = 1'b1;
         ST_D_PTR:   cmd.op_ptr = 1'b1;
         ST_D_DATA:  cmd.op_data = 1'b1;
         ST_S_START: begin
            cmd.op_start = 1'b1;
            cmd.sel_src  = 1'b1;
         end
         ST_S_PTR: begin
            cmd.op_ptr  = 1'b1;
            cmd.sel_src = 1'b1;
         end
         ST_S_DATA: begin
            cmd.op_data = 1'b1;
            cmd.sel_src = 1'b1;
         end
         ST_EXEC:    cmd.exec = 1'b1;
         ST_DIV:     cmd.div_load = status.div_done;
         ST_WRITE:   cmd.write_back = 1'b1;
         ST_RESP:    rsp_valid = 1'b1;
         default:    cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== tb/toy_cpu_execute_unit_test.sv =====
`timescale 1ns / 100ps

module toy_cpu_execute_unit_test;
   import tceu_pkg::*;

   localparam int RAM_DEPTH  = 2048;
   localparam int PROG_DEPTH = 256;
   localparam int RAND_ITEMS = 850;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   toy_cpu_execute_unit i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   // Toggle the clock every half period
   always #5 clock = ~clock;

   // Shadow copy of the machine state, advanced once per accepted item
   logic [15:0] shadow_regs [4];
   logic [15:0] shadow_ram [RAM_DEPTH];
   logic        shadow_zf, shadow_nf, shadow_of;

   rsp_type pending_rsp [$];
   int      mismatch_count = 0;
   int      unexpected_count = 0;
   bit      quiet_phase = 1'b0;   // no idling on either side
   bit      hold_off = 1'b0;      // receiver stalled for a long stretch

   // Resolve one operand: kind 0 imm, 1 reg, 2 RAM; return 0 on a range fault
   function automatic bit fetch_operand(input logic [1:0] mode, input logic [15:0] opnd,
                                        output int kind, output int idx,
                                        output logic [15:0] val);
      logic [15:0] ptr;
      kind = 0; idx = 0; val = opnd;
      case (mode)
         MODE_IMM: begin
            return 1'b1;
         end
         MODE_REG: begin
            kind = 1; idx = int'(opnd[1:0]); val = shadow_regs[idx];
            return 1'b1;
         end
         MODE_DIR: begin
            if (opnd >= RAM_DEPTH) return 1'b0;
            kind = 2; idx = int'(opnd); val = shadow_ram[opnd];
            return 1'b1;
         end
         default: begin
            if (opnd >= RAM_DEPTH) return 1'b0;
            ptr = shadow_ram[opnd];
            if (ptr[15] || ptr >= RAM_DEPTH) return 1'b0;
            kind = 2; idx = int'(ptr); val = shadow_ram[ptr];
            return 1'b1;
         end
      endcase
   endfunction

   // Execute one instruction on the shadow state and return its result item
   function automatic rsp_type execute_instr(input req_type rq);
      rsp_type     r;
      int          dk, di, sk, si;
      logic [15:0] dv, sv, res;
      int          a, b, t;
      bit          ok_d, ok_s;
      r = '0;
      if (rq.action <= OP_NOT) begin
         ok_d = fetch_operand(rq.dest_mode, rq.dest_operand, dk, di, dv);
         ok_s = fetch_operand(rq.src_mode, rq.src_operand, sk, si, sv);
         if (!ok_d || !ok_s) begin
            r.fault = 1'b1;
         end else begin
            a = int'($signed(dv)); b = int'($signed(sv)); res = dv;
            case (rq.action)
               OP_MOV: res = sv;
               OP_ADD, OP_MUL: begin
                  t = (rq.action == OP_ADD) ? a + b : a * b;
                  if (t > 255) begin
                     shadow_of = 1'b1;
                     res = 16'(t % 256);
                  end else begin
                     res = t[15:0];
                  end
               end
               OP_SUB: begin
                  t = a - b; res = t[15:0];
               end
               OP_DIV: begin
                  if (b != 0) begin
                     t = a / b; res = t[15:0];
                  end
               end
               OP_AND: res = {8'h00, dv[7:0] & sv[7:0]};
               OP_OR:  res = {8'h00, dv[7:0] | sv[7:0]};
               default: begin
                  t = 255 - a; res = t[15:0];
               end
            endcase
            if (dk == 1) shadow_regs[di] = res;
            else if (dk == 2) shadow_ram[di] = res;
            if (res == 16'd0) begin
               shadow_zf = 1'b1;
            end else if (res[15]) begin
               shadow_zf = 1'b0; shadow_nf = 1'b1;
            end else begin
               shadow_zf = 1'b0; shadow_nf = 1'b0;
            end
            r.result_value = res;
         end
      end else if (rq.action <= OP_BPOS) begin
         case (rq.action)
            OP_BZ:   r.branch_taken = shadow_zf;
            OP_BNZ:  r.branch_taken = !shadow_zf;
            OP_BNEG: r.branch_taken = shadow_nf;
            default: r.branch_taken = !shadow_nf;
         endcase
         if (r.branch_taken) r.branch_target = 8'(int'(rq.jump_target) % PROG_DEPTH);
      end
      r.reg_ax = shadow_regs[0]; r.reg_bx = shadow_regs[1];
      r.reg_cx = shadow_regs[2]; r.reg_dx = shadow_regs[3];
      r.flag_zero = shadow_zf; r.flag_negative = shadow_nf;
      r.flag_overflow = shadow_of;
      return r;
   endfunction

   // Operand generator: mostly in-range addresses and pointers, sometimes wild
   function automatic logic [15:0] pick_operand(input logic [1:0] mode);
      int sel;
      sel = int'($urandom_range(0, 19));
      if (mode == MODE_IMM || sel == 0) return 16'($urandom());
      if (mode == MODE_REG) return (sel == 1) ? 16'($urandom()) : 16'($urandom_range(0, 3));
      if (sel == 1) return 16'($urandom_range(RAM_DEPTH, 65535));
      return 16'($urandom_range(0, 15));   // small window so pointers hit written cells
   endfunction

   function automatic req_type random_instr();
      req_type rq;
      rq.action = ($urandom_range(0, 49) == 0) ? 4'($urandom_range(12, 15))
                                               : 4'($urandom_range(0, 11));
      rq.dest_mode = 2'($urandom_range(0, 3));
      rq.src_mode = 2'($urandom_range(0, 3));
      rq.dest_operand = pick_operand(rq.dest_mode);
      rq.src_operand = pick_operand(rq.src_mode);
      rq.jump_target = 8'($urandom());
      return rq;
   endfunction

   // Directed table: instruction, typed-in result, and whether to use it
   typedef struct {
      req_type instr;
      rsp_type fixed;
      bit      use_fixed;
   } directed_row_type;

   directed_row_type dir_rows [$];

   function automatic req_type mk(input logic [3:0] op, input logic [1:0] dm,
                                  input logic [15:0] dop, input logic [1:0] sm,
                                  input logic [15:0] sop, input logic [7:0] jt);
      req_type rq;
      rq.action = op; rq.dest_mode = dm; rq.dest_operand = dop;
      rq.src_mode = sm; rq.src_operand = sop; rq.jump_target = jt;
      return rq;
   endfunction

   task automatic add_row(input req_type rq);
      directed_row_type d;
      d.instr = rq; d.fixed = '0; d.use_fixed = 1'b0;
      dir_rows.push_back(d);
   endtask

   task automatic add_fixed(input req_type rq, input rsp_type r);
      directed_row_type d;
      d.instr = rq; d.fixed = r; d.use_fixed = 1'b1;
      dir_rows.push_back(d);
   endtask

   task automatic build_table();
      rsp_type f;
      // After reset: branch on zero flag clear is not taken
      f = '0;
      add_fixed(mk(OP_BZ, MODE_IMM, 16'd0, MODE_IMM, 16'd0, 8'hff), f);
      f = '0; f.branch_taken = 1'b1; f.branch_target = 8'hff;
      add_fixed(mk(OP_BNZ, MODE_IMM, 16'd0, MODE_IMM, 16'd0, 8'hff), f);
      // Out-of-range direct or indirect address faults with nothing changed
      f = '0; f.fault = 1'b1;
      add_fixed(mk(OP_MOV, MODE_DIR, 16'hffff, MODE_IMM, 16'd5, 8'd0), f);
      add_fixed(mk(OP_ADD, MODE_REG, 16'd0, MODE_IND, 16'd2048, 8'd0), f);
      // Undefined opcode does nothing
      f = '0;
      add_fixed(mk(4'd15, MODE_REG, 16'hffff, MODE_REG, 16'hffff, 8'hff), f);
      add_row(mk(OP_MOV, MODE_REG, 16'd0, MODE_IMM, 16'h8000, 8'd0));
      add_row(mk(OP_MOV, MODE_REG, 16'hfffd, MODE_IMM, 16'h7fff, 8'd0));
      add_row(mk(OP_MOV, MODE_DIR, 16'd2047, MODE_IMM, 16'd5, 8'd0));
      add_row(mk(OP_MOV, MODE_DIR, 16'd4, MODE_IMM, 16'd2047, 8'd0));
      add_row(mk(OP_ADD, MODE_IND, 16'd4, MODE_IMM, 16'd300, 8'd0));
      add_row(mk(OP_MUL, MODE_REG, 16'd1, MODE_REG, 16'd1, 8'd0));
      add_row(mk(OP_SUB, MODE_REG, 16'd0, MODE_IMM, 16'd1, 8'd0));
      add_row(mk(OP_DIV, MODE_REG, 16'd0, MODE_IMM, 16'd0, 8'd0));
      add_row(mk(OP_MOV, MODE_REG, 16'd2, MODE_IMM, 16'h8000, 8'd0));
      add_row(mk(OP_DIV, MODE_REG, 16'd2, MODE_IMM, 16'hffff, 8'd0));
      add_row(mk(OP_DIV, MODE_IMM, 16'hfff9, MODE_IMM, 16'd2, 8'd0));
      add_row(mk(OP_AND, MODE_REG, 16'd3, MODE_IMM, 16'hffff, 8'd0));
      add_row(mk(OP_OR, MODE_DIR, 16'd0, MODE_IMM, 16'h00ff, 8'd0));
      add_row(mk(OP_NOT, MODE_DIR, 16'd0, MODE_IMM, 16'd0, 8'd0));
      add_row(mk(OP_BZ, MODE_IMM, 16'd0, MODE_IMM, 16'd0, 8'h80));
      add_row(mk(OP_BNEG, MODE_IMM, 16'd0, MODE_IMM, 16'd0, 8'h01));
      add_row(mk(OP_BPOS, MODE_IMM, 16'd0, MODE_IMM, 16'd0, 8'h7f));
      // Pointer value with the sign bit set faults
      add_row(mk(OP_MOV, MODE_DIR, 16'd6, MODE_IMM, 16'h8001, 8'd0));
      add_row(mk(OP_MOV, MODE_REG, 16'd1, MODE_IND, 16'd6, 8'd0));
   endtask

   // Offer one item and hold it until accepted; valid stays high into the
   // next item unless that item idles first
   task automatic send_instr(input req_type rq);
      while (!quiet_phase && $urandom_range(0, 99) < 14) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= rq;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   // Predict at the accept edge so state follows acceptance order
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) begin
         pending_rsp.push_back(execute_instr(req_data));
      end
   end

   // Directed rows with a typed-in result are checked against that result
   rsp_type fixed_rsp [$];
   bit      fixed_flag [$];

   always @(posedge clock) begin
      rsp_type exp_rsp;
      bit      use_fix;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rsp.size() == 0) begin
            unexpected_count++;
            if (mismatch_count + unexpected_count <= 10)
               $display("unexpected result item %p", rsp_data);
         end else begin
            exp_rsp = pending_rsp.pop_front();
            use_fix = 1'b0;
            if (fixed_flag.size() > 0) begin
               use_fix = fixed_flag.pop_front();
               if (use_fix) exp_rsp = fixed_rsp.pop_front();
            end
            if (rsp_data !== exp_rsp) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: expected %p actual %p", exp_rsp, rsp_data);
            end
         end
      end
   end

   // Receiver: random stalls, plus one long hold-off counted here
   initial begin
      int hold_cycles;
      forever begin
         @(negedge clock);
         if (hold_off) begin
            rsp_ready <= 1'b0;
            for (hold_cycles = 0; hold_cycles < 300; hold_cycles++) @(negedge clock);
            hold_off = 1'b0;
         end
         rsp_ready <= quiet_phase || ($urandom_range(0, 99) >= 14);
      end
   end

   initial begin
      #50000000;
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      int n, drain;
      for (n = 0; n < 4; n++) shadow_regs[n] = '0;
      for (n = 0; n < RAM_DEPTH; n++) shadow_ram[n] = '0;
      shadow_zf = 1'b0; shadow_nf = 1'b0; shadow_of = 1'b0;
      build_table();
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // Directed part; queue each row's fixed expectation alongside
      foreach (dir_rows[k]) begin
         fixed_flag.push_back(dir_rows[k].use_fixed);
         if (dir_rows[k].use_fixed) fixed_rsp.push_back(dir_rows[k].fixed);
         send_instr(dir_rows[k].instr);
      end

      // Random part; a quiet stretch and one long receiver stall in the middle
      for (n = 0; n < RAND_ITEMS; n++) begin
         if (n == 200) quiet_phase = 1'b1;
         if (n == 300) quiet_phase = 1'b0;
         if (n == 400) hold_off = 1'b1;
         send_instr(random_instr());
      end
      req_valid <= 1'b0;

      while (pending_rsp.size() != 0) @(posedge clock);
      for (drain = 0; drain < 50; drain++) @(posedge clock);
      if (mismatch_count == 0 && unexpected_count == 0 && pending_rsp.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/tceu_pkg.sv
rtl/tceu_div.sv
rtl/tceu_dpath.sv
rtl/tceu_ctrl.sv
rtl/toy_cpu_execute_unit.sv
tb/toy_cpu_execute_unit_test.sv
